// File: rtl/core/spa_pkg.sv
// shared types, codes and constants of the slot pool allocator
package spa_pkg;

    localparam int POOL_SLOTS_DEF = 1024;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_ALL = 1'd1;

    localparam logic [2:0] OP_INIT       = 3'd0;
    localparam logic [2:0] OP_CREATE     = 3'd1;
    localparam logic [2:0] OP_CREATE_RES = 3'd2;
    localparam logic [2:0] OP_KILL       = 3'd3;
    localparam logic [2:0] OP_ADD_ACT    = 3'd4;
    localparam logic [2:0] OP_REM_ACT    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NO_CTL   = 2'd2;
    localparam logic [1:0] ST_NO_CHG   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CREATE,
        S_ADD,
        S_UNLINK,
        S_WALK,
        S_KILL,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [9:0] slot_index;
        logic       has_control;
    } t_item;

    typedef struct packed {
        logic [9:0]  given_slot;
        logic [1:0]  status;
        logic [10:0] level_slot_count;
        logic [10:0] high_water;
        logic [9:0]  active_head;
        logic        active_head_valid;
    } t_result;

endpackage

// File: rtl/core/spa_in_if.sv
// input channel of the slot pool allocator
interface spa_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [9:0] slot_index;
    logic       has_control;

    modport source (output valid, output opcode, output slot_index, output has_control,
                    input ready);
    modport sink (input valid, input opcode, input slot_index, input has_control,
                  output ready);
endinterface

// File: rtl/core/spa_out_if.sv
// result channel of the slot pool allocator
interface spa_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  given_slot;
    logic [1:0]  status;
    logic [10:0] level_slot_count;
    logic [10:0] high_water;
    logic [9:0]  active_head;
    logic        active_head_valid;

    modport source (output valid, output given_slot, output status, output level_slot_count,
                    output high_water, output active_head, output active_head_valid,
                    input ready);
    modport sink (input valid, input given_slot, input status, input level_slot_count,
                  input high_water, input active_head, input active_head_valid,
                  output ready);
endinterface

// File: rtl/core/spa_slot_mem.sv
// slot table memory, one write port and one registered read port
module spa_slot_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/spa_ctrl.sv
// sequencer of the slot pool allocator around the shared slot table
module spa_ctrl import spa_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  t_item                 i_in,
    output logic                  o_in_ready,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  logic                  i_res_ack
);
    localparam int IW = $clog2(POOL_SLOTS);
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam logic [CW-1:0] NIL = CW'(POOL_SLOTS);

    typedef struct packed {
        logic [CW-1:0] alink;
        logic [CW-1:0] flink;
        logic          killed;
        logic          active;
    } t_word;

    t_state                r_state, n_state;
    logic [2:0]            r_op, n_op;
    logic [CW-1:0]         r_s, n_s;
    logic [CW-1:0]         r_level, n_level;
    logic [CW-1:0]         r_used, n_used;
    logic [CW-1:0]         r_fhead, n_fhead;
    logic [CW-1:0]         r_afirst, n_afirst;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_next, n_next;
    t_word                 r_ws, n_ws;
    logic [IW-1:0]         r_given, n_given;
    logic [1:0]            r_status, n_status;
    logic                  r_item, n_item;
    logic [CFG_DATA_W-1:0] r_reserved;
    logic                  r_mark_all;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    t_word                 mem_wdata;
    logic [IW-1:0]         mem_raddr;
    t_word                 mem_rdata;
    logic [CW-1:0]         rsv;
    logic                  in_pool;

    spa_slot_mem #(
        .DEPTH (POOL_SLOTS),
        .WIDTH ($bits(t_word))
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= '0;
            r_mark_all <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESERVED: r_reserved <= i_cfg_wdata;
                CFG_MARK_ALL: r_mark_all <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_item   <= 1'b0;
            r_level  <= '0;
            r_used   <= '0;
            r_fhead  <= '0;
            r_afirst <= NIL;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_item   <= n_item;
            r_level  <= n_level;
            r_used   <= n_used;
            r_fhead  <= n_fhead;
            r_afirst <= n_afirst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_s      <= n_s;
        r_next   <= n_next;
        r_ws     <= n_ws;
        r_given  <= n_given;
        r_status <= n_status;
    end

    assign rsv     = (16'(r_reserved) > 16'(POOL_SLOTS)) ? NIL : CW'(r_reserved);
    assign in_pool = 16'(i_in.slot_index) < 16'(POOL_SLOTS);

    always_comb begin
        t_word w;
        w         = mem_rdata;
        n_state   = r_state;
        n_op      = r_op;
        n_s       = r_s;
        n_level   = r_level;
        n_used    = r_used;
        n_fhead   = r_fhead;
        n_afirst  = r_afirst;
        n_cnt     = r_cnt;
        n_next    = r_next;
        n_ws      = r_ws;
        n_given   = r_given;
        n_status  = r_status;
        n_item    = r_item;
        mem_we    = 1'b0;
        mem_waddr = r_s[IW-1:0];
        mem_wdata = r_ws;
        mem_raddr = r_s[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in.opcode;
                    n_s      = in_pool ? CW'(i_in.slot_index) : '0;
                    n_given  = '0;
                    n_status = ST_OK;
                    n_state  = S_FIN;
                    case (i_in.opcode)
                        OP_INIT: begin
                            n_level  = rsv;
                            n_used   = rsv;
                            n_fhead  = rsv;
                            n_afirst = NIL;
                            n_cnt    = '0;
                            n_item   = 1'b1;
                            n_state  = S_CLEAR;
                        end
                        OP_CREATE, OP_CREATE_RES: begin
                            if (r_fhead == NIL) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_raddr = r_fhead[IW-1:0];
                                n_state   = S_CREATE;
                            end
                        end
                        OP_KILL, OP_REM_ACT, OP_ADD_ACT: begin
                            mem_raddr = n_s[IW-1:0];
                            if (!in_pool) begin
                                n_status = ST_NO_CHG;
                            end else if (i_in.opcode == OP_ADD_ACT) begin
                                if (!i_in.has_control) begin
                                    n_status = ST_NO_CTL;
                                end else begin
                                    n_state = S_ADD;
                                end
                            end else begin
                                n_state = S_UNLINK;
                            end
                        end
                        default: n_status = ST_NO_CHG;
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[IW-1:0];
                mem_wdata = '{alink: '0, flink: r_cnt + CW'(1), killed: 1'b0, active: 1'b0};
                n_cnt     = r_cnt + CW'(1);
                if (r_cnt == CW'(POOL_SLOTS - 1)) begin
                    n_state = r_item ? S_FIN : S_IDLE;
                    n_item  = 1'b0;
                end
            end
            S_CREATE: begin
                w.killed  = 1'b0;
                mem_we    = 1'b1;
                mem_waddr = r_fhead[IW-1:0];
                mem_wdata = w;
                n_given   = r_fhead[IW-1:0];
                n_fhead   = mem_rdata.flink;
                if (r_used < r_fhead + CW'(1)) begin
                    n_used = r_fhead + CW'(1);
                end
                if (r_op == OP_CREATE_RES && r_level < NIL) begin
                    n_level = r_level + CW'(1);
                end
                n_state = S_FIN;
            end
            S_ADD: begin
                if (mem_rdata.active) begin
                    n_status = ST_NO_CHG;
                end else begin
                    w.active  = 1'b1;
                    w.alink   = r_afirst;
                    mem_we    = 1'b1;
                    mem_wdata = w;
                    n_afirst  = r_s;
                end
                n_state = S_FIN;
            end
            S_UNLINK: begin
                n_ws = mem_rdata;
                if (!mem_rdata.active) begin
                    if (r_op == OP_REM_ACT) begin
                        n_status = ST_NO_CHG;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_KILL;
                    end
                end else begin
                    w.active  = 1'b0;
                    n_ws      = w;
                    mem_we    = 1'b1;
                    mem_wdata = w;
                    if (r_afirst == r_s) begin
                        n_afirst = mem_rdata.alink;
                        n_state  = (r_op == OP_KILL) ? S_KILL : S_FIN;
                    end else begin
                        n_next    = mem_rdata.alink;
                        n_cnt     = r_afirst;
                        mem_raddr = r_afirst[IW-1:0];
                        n_state   = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (mem_rdata.alink == r_s) begin
                    w.alink   = r_next;
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt[IW-1:0];
                    mem_wdata = w;
                    n_state   = (r_op == OP_KILL) ? S_KILL : S_FIN;
                end else if (mem_rdata.alink >= NIL) begin
                    n_state = (r_op == OP_KILL) ? S_KILL : S_FIN;
                end else begin
                    n_cnt     = mem_rdata.alink;
                    mem_raddr = mem_rdata.alink[IW-1:0];
                end
            end
            S_KILL: begin
                w = r_ws;
                if (r_mark_all || r_s < r_level) begin
                    w.killed = 1'b1;
                end
                if (r_s >= r_level) begin
                    w.flink = r_fhead;
                    n_fhead = r_s;
                end
                mem_we    = 1'b1;
                mem_wdata = w;
                n_state   = S_TRIM_RD;
            end
            S_TRIM_RD: begin
                mem_raddr = IW'(r_used - CW'(1));
                if (r_used != '0 && r_used <= NIL) begin
                    n_state = S_TRIM_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_TRIM_CHK: begin
                if (mem_rdata.killed) begin
                    n_used  = r_used - CW'(1);
                    n_state = S_TRIM_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);

    always_comb begin
        o_res.given_slot        = 10'(r_given);
        o_res.status            = r_status;
        o_res.level_slot_count  = 11'(r_level);
        o_res.high_water        = 11'(r_used);
        o_res.active_head_valid = (r_afirst < NIL);
        o_res.active_head       = (r_afirst < NIL) ? 10'(r_afirst) : '0;
    end
endmodule

// File: rtl/core/slot_pool_allocator.sv
// top level of the slot pool allocator with the result register
// One transaction at a time, all work done by a sequencer around a single slot table
// (one write and one registered read port). Create and add-active touch one slot only,
// remove-active also walks the active list up to the slot, kill does that and then trims
// killed slots off the high-water mark, and init sweeps the whole table.
// After reset the same sweep runs with the input not ready; configuration writes are
// taken meanwhile.
// A result waits in an output register, so the next transaction can be accepted before it
// is taken.
module slot_pool_allocator import spa_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    spa_in_if.sink                i_req,
    spa_out_if.source             o_rsp
);
    t_item   req;
    t_result res;
    t_result r_out;
    logic    res_valid;
    logic    res_ack;
    logic    r_ovalid;

    assign req.opcode      = i_req.opcode;
    assign req.slot_index  = i_req.slot_index;
    assign req.has_control = i_req.has_control;

    spa_ctrl #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_req.valid),
        .i_in        (req),
        .o_in_ready  (i_req.ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ack   (res_ack)
    );

    assign res_ack = res_valid && (!r_ovalid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ack) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid             = r_ovalid;
    assign o_rsp.given_slot        = r_out.given_slot;
    assign o_rsp.status            = r_out.status;
    assign o_rsp.level_slot_count  = r_out.level_slot_count;
    assign o_rsp.high_water        = r_out.high_water;
    assign o_rsp.active_head       = r_out.active_head;
    assign o_rsp.active_head_valid = r_out.active_head_valid;
endmodule

// File: rtl/core/spa_checker.sv
// port checker of the slot pool allocator and its bind
module spa_checker import spa_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [9:0]  i_given_slot,
    input logic [1:0]  i_status,
    input logic [9:0]  i_active_head,
    input logic        i_active_head_valid
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_given_slot)
                                            && $stable(i_status)))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("ready right after a transaction");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_active_head_valid) |-> (i_active_head == 10'd0))
        else $error("active head nonzero on empty list");

    a_given_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_given_slot != 10'd0) |-> (i_status == ST_OK))
        else $error("slot given with error status");
endmodule

bind slot_pool_allocator spa_checker u_spa_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_given_slot        (o_rsp.given_slot),
    .i_status            (o_rsp.status),
    .i_active_head       (o_rsp.active_head),
    .i_active_head_valid (o_rsp.active_head_valid)
);
